// ===== design/oclbp_pkg.sv =====
// ---------------------------------------------------------------------------
// Opponent-color LBP package
// Shared types, register codes and the pattern-code function.
// ---------------------------------------------------------------------------
package oclbp_pkg;

    localparam int PIX_W       = 24;
    localparam int CHAN_W      = 8;
    localparam int CODE_W      = 8;
    localparam int WIN_SIZE    = 9;
    localparam int NBR_COUNT   = 8;

    // Configuration register widths, indexes and reset values.
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 13;
    localparam int WIDTH_CFG_W    = 12;
    localparam int HEIGHT_CFG_W   = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_PADDED_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PADDED_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EFFICIENT_ORDER = 2'd2;

    localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RESET  = 12'd642;
    localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RESET = 13'd482;
    localparam logic                    ORDER_RESET  = 1'b1;

    // Smallest frame edge the scan accepts.
    localparam int MIN_DIM = 3;

    // Channel selects inside a packed pixel.
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef logic [PIX_W-1:0]  t_pix;
    typedef logic [CODE_W-1:0] t_code;
    typedef logic [3:0]        t_pos;
    typedef t_pix              t_window [WIN_SIZE];

    typedef struct packed {
        logic emit;
        logic last;
    } t_tag;

    // Window positions 0..8 in raster order, center at 4.
    localparam t_pos RASTER_POS    [NBR_COUNT] = '{4'd0, 4'd1, 4'd2, 4'd3,
                                                   4'd5, 4'd6, 4'd7, 4'd8};
    localparam t_pos CLOCKWISE_POS [NBR_COUNT] = '{4'd0, 4'd1, 4'd2, 4'd5,
                                                   4'd8, 4'd7, 4'd6, 4'd3};

    function automatic logic [CHAN_W-1:0] chan(t_pix pix, logic [1:0] c);
        return pix[CHAN_W*c +: CHAN_W];
    endfunction

    // One bit per neighbor: set when the center is strictly greater.
    function automatic t_code lbp_code(t_window win, logic [1:0] cc, logic [1:0] nc,
                                       logic clockwise);
        t_code             code;
        logic [CHAN_W-1:0] centre;
        t_pos              p;
        code   = '0;
        centre = chan(win[4], cc);
        for (int k = 0; k < NBR_COUNT; k++) begin
            p       = clockwise ? CLOCKWISE_POS[k] : RASTER_POS[k];
            code[k] = centre > chan(win[p], nc);
        end
        return code;
    endfunction

endpackage

// ===== design/oclbp_ram.sv =====
// ---------------------------------------------------------------------------
// Generic single-clock RAM
// One write port, one read port with registered read data (old data on a
// same-address read and write).
// ---------------------------------------------------------------------------
module oclbp_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/oclbp_geom.sv =====
// ---------------------------------------------------------------------------
// Raster position tracker
// Column and row counters of the padded frame, with the interior and
// end-of-frame flags for the pixel being accepted.
// ---------------------------------------------------------------------------
module oclbp_geom #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_step,
    input  logic                                i_first,
    input  logic [oclbp_pkg::WIDTH_CFG_W-1:0]   i_width_cfg,
    input  logic [oclbp_pkg::HEIGHT_CFG_W-1:0]  i_height_cfg,
    output logic [$clog2(MAX_WIDTH)-1:0]        o_col,
    output oclbp_pkg::t_tag                     o_tag
);

    import oclbp_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WX    = (WIDTH_CFG_W > COL_W + 1) ? WIDTH_CFG_W : COL_W + 1;
    localparam int HX    = (HEIGHT_CFG_W > ROW_W + 1) ? HEIGHT_CFG_W : ROW_W + 1;

    logic [COL_W-1:0] r_col, n_col, col_eff;
    logic [ROW_W-1:0] r_row, n_row, row_eff;
    logic [WX-1:0]    width_x, w_eff, col_x;
    logic [HX-1:0]    height_x, h_eff, row_x;
    logic             row_end;

    always_comb begin
        width_x  = WX'(i_width_cfg);
        height_x = HX'(i_height_cfg);
        if (width_x < WX'(MIN_DIM)) begin
            w_eff = WX'(MIN_DIM);
        end else if (width_x > WX'(MAX_WIDTH)) begin
            w_eff = WX'(MAX_WIDTH);
        end else begin
            w_eff = width_x;
        end
        if (height_x < HX'(MIN_DIM)) begin
            h_eff = HX'(MIN_DIM);
        end else if (height_x > HX'(MAX_HEIGHT)) begin
            h_eff = HX'(MAX_HEIGHT);
        end else begin
            h_eff = height_x;
        end

        col_eff = i_first ? '0 : r_col;
        row_eff = i_first ? '0 : r_row;
        col_x   = WX'(col_eff);
        row_x   = HX'(row_eff);

        o_col      = col_eff;
        o_tag.emit = (col_x >= WX'(2)) && (row_x >= HX'(2));
        o_tag.last = (col_x == w_eff - WX'(1)) && (row_x == h_eff - HX'(1));

        // A column at or past the last one closes the row, even after a
        // geometry change in mid-frame.
        row_end = (col_x + WX'(1)) >= w_eff;
        if (row_end) begin
            n_col = '0;
            n_row = ((row_x + HX'(1)) >= h_eff) ? '0 : row_eff + ROW_W'(1);
        end else begin
            n_col = col_eff + COL_W'(1);
            n_row = row_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_step) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ===== design/oclbp_window.sv =====
// ---------------------------------------------------------------------------
// Window and pattern codes
// Shifts the 3x3 pixel window and registers the six pattern codes of an
// interior center in the output stage.
// ---------------------------------------------------------------------------
module oclbp_window (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_shift,
    input  oclbp_pkg::t_pix      i_above2,
    input  oclbp_pkg::t_pix      i_above1,
    input  oclbp_pkg::t_pix      i_pix,
    input  oclbp_pkg::t_tag      i_tag,
    input  logic                 i_clockwise,
    output logic                 o_room,
    output logic                 o_valid,
    input  logic                 i_ready,
    output oclbp_pkg::t_code     o_code_rr,
    output oclbp_pkg::t_code     o_code_gg,
    output oclbp_pkg::t_code     o_code_bb,
    output oclbp_pkg::t_code     o_code_rg,
    output oclbp_pkg::t_code     o_code_rb,
    output oclbp_pkg::t_code     o_code_gb,
    output logic                 o_last_of_frame
);

    import oclbp_pkg::*;

    t_window r_win, n_win;
    logic    r_valid;
    t_code   r_rr, r_gg, r_bb, r_rg, r_rb, r_gb;
    logic    r_last;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[3*r]     = r_win[3*r + 1];
            n_win[3*r + 1] = r_win[3*r + 2];
        end
        n_win[2] = i_above2;
        n_win[5] = i_above1;
        n_win[8] = i_pix;
    end

    assign o_room = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift && i_tag.emit) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_win <= n_win;
        end
        if (i_shift && i_tag.emit) begin
            r_rr   <= lbp_code(n_win, CH_RED,   CH_RED,   i_clockwise);
            r_gg   <= lbp_code(n_win, CH_GREEN, CH_GREEN, i_clockwise);
            r_bb   <= lbp_code(n_win, CH_BLUE,  CH_BLUE,  i_clockwise);
            r_rg   <= lbp_code(n_win, CH_RED,   CH_GREEN, 1'b0);
            r_rb   <= lbp_code(n_win, CH_RED,   CH_BLUE,  1'b0);
            r_gb   <= lbp_code(n_win, CH_GREEN, CH_BLUE,  1'b0);
            r_last <= i_tag.last;
        end
    end

    assign o_valid         = r_valid;
    assign o_code_rr       = r_rr;
    assign o_code_gg       = r_gg;
    assign o_code_bb       = r_bb;
    assign o_code_rg       = r_rg;
    assign o_code_rb       = r_rb;
    assign o_code_gb       = r_gb;
    assign o_last_of_frame = r_last;

endmodule

// ===== design/opponent_color_lbp_3x3_top.sv =====
// ---------------------------------------------------------------------------
// Opponent-color 3x3 local binary pattern, top level
// Streams a zero-padded RGB raster and gives six pattern codes per interior
// pixel.
// ---------------------------------------------------------------------------
// The block takes one pixel beat per clock unless the output stalls, and
// gives at most one code beat per pixel, registered after the first stage
// in the window stage. The rate is set by the line store, a single RAM read
// when a pixel is taken and written back as it leaves the first stage, with
// a bypass for a repeated column. Pixels of the first two rows and columns
// give no beat. The line store needs no clearing after reset; write geometry
// and order registers only while no pixel is in flight.
module opponent_color_lbp_3x3_top #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [7:0]                         i_red,
    input  logic [7:0]                         i_green,
    input  logic [7:0]                         i_blue,
    input  logic                               i_first_of_frame,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [7:0]                         o_code_rr,
    output logic [7:0]                         o_code_gg,
    output logic [7:0]                         o_code_bb,
    output logic [7:0]                         o_code_rg,
    output logic [7:0]                         o_code_rb,
    output logic [7:0]                         o_code_gb,
    output logic                               o_last_of_frame,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [oclbp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [oclbp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import oclbp_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic [WIDTH_CFG_W-1:0]  r_padded_width;
    logic [HEIGHT_CFG_W-1:0] r_padded_height;
    logic                    r_efficient_order;

    logic               in_acc;
    logic [COL_W-1:0]   col;
    t_tag               tag;

    logic               r_s1_valid;
    t_pix               r_s1_pix;
    logic [COL_W-1:0]   r_s1_col;
    t_tag               r_s1_tag;
    logic               r_fwd;
    logic [2*PIX_W-1:0] r_fwd_data;

    logic [2*PIX_W-1:0] ram_rdata, lines, wdata;
    logic               s1_adv, room;

    // Configuration beats are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_padded_width    <= WIDTH_RESET;
            r_padded_height   <= HEIGHT_RESET;
            r_efficient_order <= ORDER_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PADDED_WIDTH:    r_padded_width    <= i_cfg_data[WIDTH_CFG_W-1:0];
                CFG_PADDED_HEIGHT:   r_padded_height   <= i_cfg_data[HEIGHT_CFG_W-1:0];
                CFG_EFFICIENT_ORDER: r_efficient_order <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    oclbp_geom #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_geom (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (in_acc),
        .i_first      (i_first_of_frame),
        .i_width_cfg  (r_padded_width),
        .i_height_cfg (r_padded_height),
        .o_col        (col),
        .o_tag        (tag)
    );

    // Upper line in the high half, lower line in the low half.
    oclbp_ram #(
        .WIDTH (2*PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_col),
        .i_wdata (wdata),
        .i_re    (in_acc),
        .i_raddr (col),
        .o_rdata (ram_rdata)
    );

    assign lines  = r_fwd ? r_fwd_data : ram_rdata;
    assign wdata  = {lines[PIX_W-1:0], r_s1_pix};
    assign s1_adv = r_s1_valid && (!r_s1_tag.emit || room);
    assign o_ready = !r_s1_valid || s1_adv;
    assign in_acc  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // When the same column is read while it is being written, the RAM
    // returns the old line, so the new one is carried alongside.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix   <= {i_blue, i_green, i_red};
            r_s1_col   <= col;
            r_s1_tag   <= tag;
            r_fwd      <= s1_adv && (r_s1_col == col);
            r_fwd_data <= wdata;
        end
    end

    oclbp_window u_window (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_shift         (s1_adv),
        .i_above2        (lines[2*PIX_W-1:PIX_W]),
        .i_above1        (lines[PIX_W-1:0]),
        .i_pix           (r_s1_pix),
        .i_tag           (r_s1_tag),
        .i_clockwise     (r_efficient_order),
        .o_room          (room),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_code_rr       (o_code_rr),
        .o_code_gg       (o_code_gg),
        .o_code_bb       (o_code_bb),
        .o_code_rg       (o_code_rg),
        .o_code_rb       (o_code_rb),
        .o_code_gb       (o_code_gb),
        .o_last_of_frame (o_last_of_frame)
    );

endmodule
